FILE: design/sbec_pkg.sv
// shared types and constants for the segment box entry clipper
`default_nettype none
package sbec_pkg;

	// coordinate width (signed q16.16) and entry parameter width (q0.30 fraction)
	localparam int CW = 32;
	localparam int TW = 30;

	// quotient bits resolved in each divider stage
	localparam int DIV_BITS   = 3;
	localparam int DIV_STAGES = TW / DIV_BITS;

	// number of axes
	localparam int NAX = 3;

	// result codes
	typedef enum logic [1:0] {
		HIT_MISS   = 2'd0,
		HIT_ENTER  = 2'd1,
		HIT_INSIDE = 2'd2
	} hit_code_t;

	// one request: segment start, segment end, box corners
	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] start_z;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] end_z;
		logic signed [CW-1:0] box_min_x;
		logic signed [CW-1:0] box_min_y;
		logic signed [CW-1:0] box_min_z;
		logic signed [CW-1:0] box_max_x;
		logic signed [CW-1:0] box_max_y;
		logic signed [CW-1:0] box_max_z;
	} req_t;

	// one result
	typedef struct packed {
		logic [1:0]           hit_code;
		logic signed [CW-1:0] hit_x;
		logic signed [CW-1:0] hit_y;
		logic signed [CW-1:0] hit_z;
	} res_t;

	// geometry that travels alongside the dividers
	typedef struct packed {
		logic [NAX-1:0][CW-1:0] st;
		logic [NAX-1:0][CW-1:0] lo;
		logic [NAX-1:0][CW-1:0] hi;
		logic [NAX-1:0][CW-1:0] plane;
		logic [NAX-1:0][CW-1:0] dmag;
		logic [NAX-1:0]         dneg;
		logic [NAX-1:0]         tried;
		logic                   outside;
	} geo_t;

endpackage
`default_nettype wire

FILE: design/sbec_div.sv
// pipelined restoring divider giving a truncated q0.30 ratio num/den (num < den)
`default_nettype none
module sbec_div (
	input  wire logic                    clk,
	input  wire logic [sbec_pkg::CW-1:0] num,
	input  wire logic [sbec_pkg::CW-1:0] den,
	output logic      [sbec_pkg::TW-1:0] quo
);
	import sbec_pkg::*;

	typedef struct packed {
		logic [CW-1:0] rem;
		logic [TW-1:0] quo;
	} div_st_t;

	// DIV_BITS shift and subtract steps
	function automatic div_st_t div_step(div_st_t cur, logic [CW-1:0] d);
		div_st_t    nxt;
		logic [CW:0] sh;
		nxt = cur;
		for (int i = 0; i < DIV_BITS; i++) begin
			sh      = {nxt.rem, 1'b0};
			nxt.quo = {nxt.quo[TW-2:0], 1'b0};
			if (sh >= {1'b0, d}) begin
				sh         = sh - {1'b0, d};
				nxt.quo[0] = 1'b1;
			end
			nxt.rem = sh[CW-1:0];
		end
		return nxt;
	endfunction

	div_st_t       st_s  [DIV_STAGES];
	logic [CW-1:0] den_s [DIV_STAGES];

	// first stage takes the operands
	always_ff @(posedge clk) begin
		st_s[0]  <= div_step('{rem: num, quo: '0}, den);
		den_s[0] <= den;
	end

	// remaining stages
	for (genvar g = 1; g < DIV_STAGES; g++) begin : g_stage
		always_ff @(posedge clk) begin
			st_s[g]  <= div_step(st_s[g-1], den_s[g-1]);
			den_s[g] <= den_s[g-1];
		end
	end

	assign quo = st_s[DIV_STAGES-1].quo;

endmodule
`default_nettype wire

FILE: design/segment_box_entry_clip_top.sv
// top level of the segment versus box entry clipper
`default_nettype none
// Segment versus axis-aligned box entry test, signed q16.16 coordinates.
// Request channel: req is taken at a rising edge with start high and busy low.
// busy is always low, so a new request may be issued on every cycle.
// Result channel: res is valid for exactly one cycle while done is high;
// the receiver takes it at the edge ending that cycle and cannot stall it.
// Throughput: one request per cycle. Depth is set by the entry parameter
// dividers (ten stages of three quotient bits each, one per axis), followed
// by a multiply stage for the interpolation, an add stage, an on-face check
// stage and a face choice stage feeding the output register.
// Results come out in request order, one per request.
// Codes: miss (zero point), segment enters box (entry point), start inside
// (start point). Faces are tried x, then y, then z; a later face needs a
// strictly smaller t.
// Reset clears only the valid bits; requests in flight are dropped.
module segment_box_entry_clip_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire sbec_pkg::req_t req,
	output logic                done,
	output sbec_pkg::res_t      res
);
	import sbec_pkg::*;

	localparam int LAT = DIV_STAGES + 5;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits
	logic [LAT-1:0] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	// stage 1: face candidates, numerators and deltas
	geo_t          geo_d;
	logic [NAX-1:0][CW-1:0] num_d;
	logic [NAX-1:0][CW-1:0] num_s1;
	geo_t          geo_s1;

	always_comb begin
		logic signed [CW-1:0] s, e, l, h;
		logic signed [CW:0]   dd, nn;
		geo_d = '0;
		num_d = '0;
		geo_d.st = {req.start_z, req.start_y, req.start_x};
		geo_d.lo = {req.box_min_z, req.box_min_y, req.box_min_x};
		geo_d.hi = {req.box_max_z, req.box_max_y, req.box_max_x};
		for (int a = 0; a < NAX; a++) begin
			s  = $signed(geo_d.st[a]);
			l  = $signed(geo_d.lo[a]);
			h  = $signed(geo_d.hi[a]);
			e  = (a == 0) ? req.end_x : ((a == 1) ? req.end_y : req.end_z);
			dd = {e[CW-1], e} - {s[CW-1], s};
			geo_d.dneg[a] = dd[CW];
			geo_d.dmag[a] = dd[CW] ? CW'(-dd) : dd[CW-1:0];
			geo_d.plane[a] = l;
			nn = {l[CW-1], l} - {s[CW-1], s};
			if (s <= l) begin
				geo_d.outside  = 1'b1;
				geo_d.tried[a] = l < e;
			end else if (h <= s) begin
				geo_d.outside  = 1'b1;
				geo_d.tried[a] = e < h;
				geo_d.plane[a] = h;
				nn = {s[CW-1], s} - {h[CW-1], h};
			end
			num_d[a] = nn[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		geo_s1 <= geo_d;
		num_s1 <= num_d;
	end

	// stages 2 to 11: entry parameter per axis
	logic [NAX-1:0][TW-1:0] t_dv;
	for (genvar a = 0; a < NAX; a++) begin : g_div
		sbec_div u_div (
			.clk (clk),
			.num (num_s1[a]),
			.den (geo_s1.dmag[a]),
			.quo (t_dv[a])
		);
	end

	geo_t geo_dv_s [DIV_STAGES];
	always_ff @(posedge clk) begin
		geo_dv_s[0] <= geo_s1;
		for (int i = 1; i < DIV_STAGES; i++) begin
			geo_dv_s[i] <= geo_dv_s[i-1];
		end
	end

	// stage 12: partial products of |d_k| * t_a
	logic [NAX-1:0][NAX-1:0][2*TW-1:0] plo_s12;
	logic [NAX-1:0][NAX-1:0][CW-1:0]   phi_s12;
	logic [NAX-1:0][TW-1:0]            t_s12;
	geo_t                              geo_s12;

	always_ff @(posedge clk) begin
		for (int a = 0; a < NAX; a++) begin
			for (int k = 0; k < NAX; k++) begin
				plo_s12[a][k] <= geo_dv_s[DIV_STAGES-1].dmag[k][TW-1:0] * t_dv[a];
				phi_s12[a][k] <= CW'(geo_dv_s[DIV_STAGES-1].dmag[k][CW-1:TW] * t_dv[a]);
			end
		end
		t_s12   <= t_dv;
		geo_s12 <= geo_dv_s[DIV_STAGES-1];
	end

	// stage 13: interpolated coordinates, plane value on the entry axis
	logic [NAX-1:0][NAX-1:0][CW-1:0] c_s13;
	logic [NAX-1:0][TW-1:0]          t_s13;
	geo_t                            geo_s13;

	always_ff @(posedge clk) begin
		logic [CW-1:0] p;
		for (int a = 0; a < NAX; a++) begin
			for (int k = 0; k < NAX; k++) begin
				p = phi_s12[a][k] + CW'(plo_s12[a][k][2*TW-1:TW]);
				if (k == a) begin
					c_s13[a][k] <= geo_s12.plane[a];
				end else if (geo_s12.dneg[k]) begin
					c_s13[a][k] <= geo_s12.st[k] - p;
				end else begin
					c_s13[a][k] <= geo_s12.st[k] + p;
				end
			end
		end
		t_s13   <= t_s12;
		geo_s13 <= geo_s12;
	end

	// stage 14: on-face check per candidate face
	logic [NAX-1:0][NAX-1:0][CW-1:0] c_s14;
	logic [NAX-1:0][TW-1:0]          t_s14;
	logic [NAX-1:0]                  ok_s14;
	logic [NAX-1:0][CW-1:0]          st_s14;
	logic                            outside_s14;

	always_ff @(posedge clk) begin
		logic ok;
		for (int a = 0; a < NAX; a++) begin
			ok = geo_s13.tried[a];
			for (int k = 0; k < NAX; k++) begin
				if (k != a) begin
					if ($signed(c_s13[a][k]) < $signed(geo_s13.lo[k]) ||
					    $signed(c_s13[a][k]) > $signed(geo_s13.hi[k])) begin
						ok = 1'b0;
					end
				end
			end
			ok_s14[a] <= ok;
		end
		c_s14       <= c_s13;
		t_s14       <= t_s13;
		st_s14      <= geo_s13.st;
		outside_s14 <= geo_s13.outside;
	end

	// stage 15: face choice in axis order and output register
	res_t res_d;
	always_comb begin
		logic          have;
		logic [TW-1:0] best;
		logic [NAX-1:0][CW-1:0] pt;
		have = 1'b0;
		best = '0;
		pt   = '0;
		for (int a = 0; a < NAX; a++) begin
			if (ok_s14[a] && (!have || t_s14[a] < best)) begin
				have = 1'b1;
				best = t_s14[a];
				pt   = c_s14[a];
			end
		end
		if (!outside_s14) begin
			res_d.hit_code = HIT_INSIDE;
			pt = st_s14;
		end else if (have) begin
			res_d.hit_code = HIT_ENTER;
		end else begin
			res_d.hit_code = HIT_MISS;
			pt = '0;
		end
		res_d.hit_x = pt[0];
		res_d.hit_y = pt[1];
		res_d.hit_z = pt[2];
	end

	always_ff @(posedge clk) begin
		res <= res_d;
	end

	assign done = vld_s[LAT-1];

endmodule
`default_nettype wire
